// ===== design/tsd_pkg.sv =====
// Package for the textured span drawer: payload types, codes and sizes.
`timescale 1ns / 1ps
`default_nettype none
package tsd_pkg;

    localparam logic [15:0] SCREEN_WIDTH = 16'd320;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam int TEX_AW  = 12;
    localparam int CMAP_AW = 8;
    localparam int TINT_AW = 16;
    localparam int CFG_IDX_W = 2;

    // input function codes
    localparam logic [2:0] FUNC_TEX_WRITE  = 3'd0;
    localparam logic [2:0] FUNC_CMAP_WRITE = 3'd1;
    localparam logic [2:0] FUNC_TINT_WRITE = 3'd2;
    localparam logic [2:0] FUNC_SPAN_START = 3'd3;
    localparam logic [2:0] FUNC_PIXEL      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_COLOR  = 2'd2;

    // blend modes
    localparam logic [1:0] BLEND_PLAIN   = 2'd0;
    localparam logic [1:0] BLEND_NEW_OLD = 2'd1;
    localparam logic [1:0] BLEND_OLD_NEW = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [15:0]        index;
        logic [7:0]         data;
        logic signed [31:0] frac_x;
        logic signed [31:0] frac_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic [8:0]         x_first;
        logic [8:0]         x_last;
        logic [7:0]         row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_address;
        logic [7:0]  color;
        logic        write_enable;
        logic        span_done;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_TEX   = 2'd0,
        JOB_CMAP  = 2'd1,
        JOB_TINT  = 2'd2,
        JOB_PIXEL = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [TINT_AW-1:0] waddr;
        logic [7:0]        data;
        logic [TEX_AW-1:0] tex_idx;
        logic [15:0]       pixel_address;
        logic              span_done;
    } t_job;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_write;

endpackage
`default_nettype wire

// ===== design/tsd_front.sv =====
// Front end: accepts items, keeps the span walker state and issues jobs.
`timescale 1ns / 1ps
`default_nettype none
module tsd_front
    import tsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    input  wire logic     i_queue_full,
    output logic          o_job_valid,
    output t_job          o_job
);

    logic [31:0] r_position, n_position;
    logic [31:0] r_step, n_step;
    logic [15:0] r_next_address, n_next_address;
    logic [8:0]  r_pixels_left, n_pixels_left;
    logic        r_span_active, n_span_active;
    logic        accept;

    assign accept = i_push && !i_queue_full;

    always_comb begin
        n_position     = r_position;
        n_step         = r_step;
        n_next_address = r_next_address;
        n_pixels_left  = r_pixels_left;
        n_span_active  = r_span_active;
        o_job_valid    = 1'b0;
        o_job.kind          = JOB_TEX;
        o_job.waddr         = i_item.index;
        o_job.data          = i_item.data;
        o_job.tex_idx       = {r_position[15:10], r_position[31:26]};
        o_job.pixel_address = r_next_address;
        o_job.span_done     = (r_pixels_left == 9'd0);
        case (i_item.func)
            FUNC_TEX_WRITE: begin
                o_job.kind  = JOB_TEX;
                o_job_valid = accept;
            end
            FUNC_CMAP_WRITE: begin
                o_job.kind  = JOB_CMAP;
                o_job_valid = accept;
            end
            FUNC_TINT_WRITE: begin
                o_job.kind  = JOB_TINT;
                o_job_valid = accept;
            end
            FUNC_SPAN_START: begin
                if (accept) begin
                    // x and y bits 21..6 side by side: y carries into x
                    n_position = {i_item.frac_x[21:6], i_item.frac_y[21:6]};
                    n_step     = {i_item.step_x[21:6], i_item.step_y[21:6]};
                    n_next_address = {8'd0, i_item.row} * SCREEN_WIDTH
                                     + {7'd0, i_item.x_first};
                    if (i_item.x_last < i_item.x_first) begin
                        n_pixels_left = 9'd0;
                        n_span_active = 1'b0;
                    end else begin
                        n_pixels_left = i_item.x_last - i_item.x_first;
                        n_span_active = 1'b1;
                    end
                end
            end
            FUNC_PIXEL: begin
                o_job.kind = JOB_PIXEL;
                if (accept && r_span_active) begin
                    o_job_valid    = 1'b1;
                    n_position     = r_position + r_step;
                    n_next_address = r_next_address + 16'd1;
                    if (r_pixels_left == 9'd0) begin
                        n_span_active = 1'b0;
                    end else begin
                        n_pixels_left = r_pixels_left - 9'd1;
                    end
                end
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= '0;
            r_step         <= '0;
            r_next_address <= '0;
            r_pixels_left  <= '0;
            r_span_active  <= 1'b0;
        end else begin
            r_position     <= n_position;
            r_step         <= n_step;
            r_next_address <= n_next_address;
            r_pixels_left  <= n_pixels_left;
            r_span_active  <= n_span_active;
        end
    end

endmodule
`default_nettype wire

// ===== design/tsd_queue.sv =====
// Job queue between the front end and the table pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tsd_queue
    import tsd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/tsd_back.sv =====
// Back end: texture, colormap and tint lookups, masking and result buffer.
`timescale 1ns / 1ps
`default_nettype none
module tsd_back
    import tsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg_write i_cfg,
    input  wire logic       i_job_valid,
    input  wire t_job       i_job,
    output logic            o_job_pop,
    output logic            o_empty,
    input  wire logic       i_pop,
    output t_out_item       o_out
);

    // configuration
    logic [1:0] r_blend_mode;
    logic       r_mask_enable;
    logic [7:0] r_mask_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode  <= BLEND_PLAIN;
            r_mask_enable <= 1'b0;
            r_mask_color  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BLEND_MODE:  r_blend_mode  <= i_cfg.data[1:0];
                CFG_MASK_ENABLE: r_mask_enable <= i_cfg.data[0];
                CFG_MASK_COLOR:  r_mask_color  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // tables
    logic [7:0] r_tex_ram  [2**TEX_AW];
    logic [7:0] r_cmap_ram [2**CMAP_AW];
    logic [7:0] r_tint_ram [2**TINT_AW];

    // result buffer, two entries
    t_out_item r_obuf [2];
    logic      r_owptr, r_orptr;
    logic [1:0] r_ocount;
    logic      out_pop, out_push, en;
    t_out_item result;

    assign out_pop   = i_pop && (r_ocount != 2'd0);
    // the whole pipe moves together; it stalls only when the buffer is full
    assign en        = (r_ocount != 2'd2) || out_pop;
    assign o_job_pop = en && i_job_valid;

    // pipeline stages
    logic       r_v1, r_v2, r_v3;
    t_job       r_j1, r_j2, r_j3;
    logic [7:0] r_raw, r_cmap_q, r_plain3, r_tint_q;
    logic       r_we2, r_we3;
    logic [TINT_AW-1:0] tint_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1 <= i_job;
            r_j2 <= r_j1;
            r_j3 <= r_j2;
        end
    end

    // stage 1: texel
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_job_valid && i_job.kind == JOB_TEX) begin
                r_tex_ram[i_job.waddr[TEX_AW-1:0]] <= i_job.data;
            end
            r_raw <= r_tex_ram[i_job.tex_idx];
        end
    end

    // stage 2: colormap and mask test on the raw texel
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_v1 && r_j1.kind == JOB_CMAP) begin
                r_cmap_ram[r_j1.waddr[CMAP_AW-1:0]] <= r_j1.data;
            end
            r_cmap_q <= r_cmap_ram[r_raw];
            r_we2    <= !(r_mask_enable && (r_raw == r_mask_color));
        end
    end

    assign tint_addr = (r_blend_mode == BLEND_OLD_NEW) ? {r_j2.data, r_cmap_q}
                                                       : {r_cmap_q, r_j2.data};

    // stage 3: tint
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_v2 && r_j2.kind == JOB_TINT) begin
                r_tint_ram[r_j2.waddr] <= r_j2.data;
            end
            r_tint_q <= r_tint_ram[tint_addr];
            r_plain3 <= r_cmap_q;
            r_we3    <= r_we2;
        end
    end

    always_comb begin
        result.pixel_address = r_j3.pixel_address;
        result.write_enable  = r_we3;
        result.span_done     = r_j3.span_done;
        if (!r_we3) begin
            result.color = r_j3.data;
        end else if (r_blend_mode == BLEND_NEW_OLD || r_blend_mode == BLEND_OLD_NEW) begin
            result.color = r_tint_q;
        end else begin
            result.color = r_plain3;
        end
    end

    assign out_push = en && r_v3 && (r_j3.kind == JOB_PIXEL);
    assign o_empty  = (r_ocount == 2'd0);
    assign o_out    = r_obuf[r_orptr];

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_obuf[r_owptr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr  <= 1'b0;
            r_orptr  <= 1'b0;
            r_ocount <= '0;
        end else begin
            if (out_push) begin
                r_owptr <= ~r_owptr;
            end
            if (out_pop) begin
                r_orptr <= ~r_orptr;
            end
            r_ocount <= r_ocount + 2'(out_push) - 2'(out_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/textured_span_drawer.sv =====
// Textured span drawer: 64x64 affine texture spans, one pixel per clock.
//
// Input channel (push/full): table writes load the texture, colormap and
// tint tables; a span start sets position, step, address and pixel count;
// each pixel transaction brings the old destination pixel in data and yields
// one result. Spans that are reversed, pixels while idle and unused function
// codes yield nothing.
// Result channel (empty/pop): address, colour, write enable, end of span.
// Config channel (valid/ready): ready is always high; write only while idle.
// Throughput: one transaction per clock unless the pipeline stalls, set by
// the front end span walker and the three chained table reads, each one
// pipeline stage. A pixel passes the job queue, the three table stages and
// the result buffer. When pop is held low the two-entry result buffer fills,
// the table pipeline freezes, the job queue fills and full rises; nothing is
// lost. Reset clears the span state, the queues and the registers; the
// tables are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module textured_span_drawer
    import tsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire t_in_item             i_in,
    output logic                      full,
    output logic                      empty,
    input  wire logic                 pop,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    logic       front_valid;
    t_job       front_job;
    logic       queue_pop, queue_empty;
    t_job       queue_job;
    t_cfg_write cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    tsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in),
        .i_queue_full (full),
        .o_job_valid  (front_valid),
        .o_job        (front_job)
    );

    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    tsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (!queue_empty),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
